// File: src/tmd_pkg.sv
// tmd_pkg: shared types and constants of the turn mark detector
// sample classes, carriage kinds, register indexes and matcher result
// no dependencies
package tmd_pkg;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned HIST_DEPTH = 3;

	localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 10'd400;
	localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST = 10'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_THRESHOLD = 2'd0,
		REG_LOW_THRESHOLD = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_NEUTRAL = 2'd0,
		CLS_HIGH = 2'd1,
		CLS_LOW = 2'd2
	} cls_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_K = 2'd1,
		KIND_L = 2'd2,
		KIND_G = 2'd3
	} kind_t;

	// newest class at index 0
	typedef cls_t hist_t [HIST_DEPTH];

	typedef struct packed {
		logic hit;
		kind_t kind;
	} match_t;

endpackage

// File: src/tmd_if.sv
// tmd_if: valid/ready channels of the turn mark detector
// sample items, result items and the register write channel
// depends on tmd_pkg
interface tmd_sample_if import tmd_pkg::*; ();
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tmd_result_if import tmd_pkg::*; ();
	logic valid;
	logic ready;
	logic mark_pulse;
	logic over_mark;
	logic [1:0] carriage_kind;

	modport source (output valid, output mark_pulse, output over_mark,
		output carriage_kind, input ready);
	modport sink (input valid, input mark_pulse, input over_mark,
		input carriage_kind, output ready);
endinterface

interface tmd_cfg_if import tmd_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SAMPLE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/tmd_match.sv
// tmd_match: turn mark pattern matcher over the class history
// priority K, then L, then G; combinational
// depends on tmd_pkg
module tmd_match import tmd_pkg::*; (
	input hist_t hist,
	output match_t match
);

	function automatic logic seen(input hist_t h, input cls_t a, input cls_t b, input cls_t c);
		seen = (h[0] == a) && (h[1] == b) && (h[2] == c);
	endfunction

	logic hit_k;
	logic hit_l;
	logic hit_g;

	always_comb begin
		hit_k = seen(hist, CLS_HIGH, CLS_HIGH, CLS_NEUTRAL)
			|| seen(hist, CLS_NEUTRAL, CLS_HIGH, CLS_HIGH)
			|| seen(hist, CLS_HIGH, CLS_HIGH, CLS_HIGH);
		hit_l = seen(hist, CLS_LOW, CLS_LOW, CLS_NEUTRAL)
			|| seen(hist, CLS_NEUTRAL, CLS_LOW, CLS_LOW)
			|| seen(hist, CLS_LOW, CLS_LOW, CLS_LOW);
		hit_g = seen(hist, CLS_LOW, CLS_NEUTRAL, CLS_HIGH)
			|| seen(hist, CLS_HIGH, CLS_NEUTRAL, CLS_LOW)
			|| seen(hist, CLS_HIGH, CLS_HIGH, CLS_LOW)
			|| seen(hist, CLS_HIGH, CLS_LOW, CLS_LOW);
		match.hit = hit_k || hit_l || hit_g;
		if (hit_k) begin
			match.kind = KIND_K;
		end else if (hit_l) begin
			match.kind = KIND_L;
		end else if (hit_g) begin
			match.kind = KIND_G;
		end else begin
			match.kind = KIND_UNKNOWN;
		end
	end

endmodule

// File: src/turn_mark_detector_top.sv
// Turn mark detector: each sample item is classified high, neutral or low against two
// programmable thresholds, the last three classes are matched against the K, L and G
// turn mark patterns, and one result item (rising-edge pulse, over-mark flag, held
// carriage kind) comes back per sample. One item is taken every clock cycle while not
// stalled, passing the sample register and then the result register. The result
// register stalls the sample stage while a result waits and results.ready is low.
// Users must write thresholds through the register channel while idle; not enforced.
// depends on tmd_pkg, tmd_if and tmd_match
module turn_mark_detector_top import tmd_pkg::*; (
	input logic clk,
	input logic arst_n,
	tmd_sample_if.sink samples,
	tmd_result_if.source results,
	tmd_cfg_if.sink cfg
);

	logic [SAMPLE_W-1:0] high_thr_q;
	logic [SAMPLE_W-1:0] low_thr_q;

	logic valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic valid_s2;
	logic mark_pulse_s2;
	logic over_mark_s2;
	kind_t kind_s2;

	hist_t hist_q;
	hist_t hist_next;
	logic over_q;
	kind_t kind_q;

	logic advance;
	cls_t cls;
	match_t match;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THRESHOLD_RST;
			low_thr_q <= LOW_THRESHOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HIGH_THRESHOLD: high_thr_q <= cfg.data;
				REG_LOW_THRESHOLD: low_thr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance = !valid_s2 || results.ready;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			sample_s1 <= samples.sample;
		end
	end

	// classify and shift history
	always_comb begin
		if (sample_s1 >= high_thr_q) begin
			cls = CLS_HIGH;
		end else if (sample_s1 >= low_thr_q) begin
			cls = CLS_NEUTRAL;
		end else begin
			cls = CLS_LOW;
		end
		hist_next[0] = cls;
		hist_next[1] = hist_q[0];
		hist_next[2] = hist_q[1];
	end

	tmd_match u_match (
		.hist (hist_next),
		.match (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= CLS_NEUTRAL;
			hist_q[1] <= CLS_NEUTRAL;
			hist_q[2] <= CLS_NEUTRAL;
			over_q <= 1'b0;
			kind_q <= KIND_UNKNOWN;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				hist_q <= hist_next;
				over_q <= match.hit;
				if (match.hit) begin
					kind_q <= match.kind;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			mark_pulse_s2 <= match.hit && !over_q;
			over_mark_s2 <= match.hit;
			kind_s2 <= match.hit ? match.kind : kind_q;
		end
	end

	assign results.valid = valid_s2;
	assign results.mark_pulse = mark_pulse_s2;
	assign results.over_mark = over_mark_s2;
	assign results.carriage_kind = kind_s2;

endmodule
